### rtl/core/dpcfd_pkg.sv
// Shared constants, command table, record type and helper functions of the frame decoder.
package dpcfd_pkg;

   localparam int FRAME_DEPTH = 32;
   localparam int IDX_W = $clog2(FRAME_DEPTH);
   localparam int BIN_LEN = 5;
   localparam int CFG_W = 24;
   localparam int FREQ_W = 24;
   localparam int FREQ_DIGITS = 7;
   localparam int REC_BYTES = 12;
   localparam int TERM_SPAN = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] TERM_CHAR = 8'h3B;
   localparam logic [7:0] TOGGLE_OP = 8'h05;
   localparam logic [7:0] OP_FREQ_LO = 8'h0A;
   localparam logic [7:0] OP_FREQ_HI = 8'h0F;
   localparam logic [7:0] CMD_FA_SET = 8'd7;
   localparam logic [7:0] CMD_FB_SET = 8'd8;
   localparam logic [7:0] CMD_MODE_SET = 8'd41;
   localparam logic [7:0] MODE_C0 = "2";
   localparam logic [7:0] MODE_C1 = "E";
   localparam int MODE_TERM_POS = 3;
   localparam logic [7:0] MODE_ARG_BIN = "0";
   localparam logic [7:0] MODE_ARG_ASCII = "1";

   localparam logic CSR_LOWER = 1'b0;
   localparam logic CSR_UPPER = 1'b1;
   localparam logic [CFG_W-1:0] LOWER_RESET = 24'd0;
   localparam logic [CFG_W-1:0] UPPER_RESET = 24'd9999999;

   localparam int CMD_COUNT = 42;
   localparam logic [7:0] CMD_C0 [CMD_COUNT] = '{
      "I","A","D","U","F","F","F","F","F","F","F","F","F","I","I","L","L","M","M","M",
      "M","R","R","R","R","R","T","S","S","Y","1","1","1","1","1","2","2","2","2","2",
      "3","3"};
   localparam logic [7:0] CMD_C1 [CMD_COUNT] = '{
      "D","I","N","P","A","B","A","B","N","R","R","T","T","F","E","K","K","C","D","R",
      "W","C","D","U","T","X","X","C","P","A","A","B","C","D","E","A","B","C","D","E",
      "0","1"};
   localparam logic [4:0] CMD_POS [CMD_COUNT] = '{
      5'd2, 5'd3, 5'd2, 5'd2, 5'd2, 5'd2, 5'd13, 5'd13, 5'd3, 5'd3, 5'd2, 5'd3, 5'd2,
      5'd2, 5'd3, 5'd2, 5'd3, 5'd5, 5'd3, 5'd6, 5'd23, 5'd2, 5'd2, 5'd2, 5'd3, 5'd2,
      5'd2, 5'd3, 5'd3, 5'd2, 5'd3, 5'd3, 5'd3, 5'd7, 5'd2, 5'd3, 5'd4, 5'd3, 5'd3,
      5'd3, 5'd2, 5'd2};
   localparam logic [7:0] CMD_CODE [CMD_COUNT] = '{
      8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13,
      8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24,
      8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35,
      8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd43, 8'd44};

   localparam logic [FREQ_W-1:0] DEC_WEIGHT [FREQ_DIGITS] = '{
      24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000};

   typedef struct packed {
      logic                          ovr;
      logic                          mode_after;
      logic                          toggled;
      logic                          dec_bin;
      logic [REC_BYTES-1:0][7:0]     bytes;
      logic [TERM_SPAN-1:0]          term;
   } frame_rec_type;

   function automatic logic [7:0] cmd_lookup(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [TERM_SPAN-1:0] term);
      logic [7:0] code;
      code = 8'd0;
      for (int i = CMD_COUNT - 1; i >= 0; i--) begin
         if (c0 == CMD_C0[i] && c1 == CMD_C1[i] && term[CMD_POS[i]]) begin
            code = CMD_CODE[i];
         end
      end
      return code;
   endfunction

   function automatic logic [FREQ_W-1:0] join_digits(
      input logic [FREQ_DIGITS-1:0][3:0] d);
      logic [FREQ_W-1:0] sum;
      sum = '0;
      for (int k = 0; k < FREQ_DIGITS; k++) begin
         sum = sum + FREQ_W'(d[k] * DEC_WEIGHT[k]);
      end
      return sum;
   endfunction

endpackage

### rtl/core/dpcfd_if.sv
// Request and response channel interfaces of the frame decoder.
interface dpcfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface dpcfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        protocol;
   logic [7:0]  command_code;
   logic [23:0] frequency;
   logic        freq_present;
   logic        freq_in_range;
   logic [7:0]  param_char;
   logic        mode_toggled;
   logic        overrun;
   modport source (output valid, output protocol, output command_code, output frequency,
                   output freq_present, output freq_in_range, output param_char,
                   output mode_toggled, output overrun, input ready);
   modport sink (input valid, input protocol, input command_code, input frequency,
                 input freq_present, input freq_in_range, input param_char,
                 input mode_toggled, input overrun, output ready);
endinterface

### rtl/core/dpcfd_front.sv
// Front end: stores bytes, finds frame ends, tracks the protocol mode and emits frame records.
module dpcfd_front import dpcfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [7:0]    in_byte,
   output logic          in_ready,
   input  logic          q_space,
   output logic          rec_valid,
   output frame_rec_type rec
);

   logic [7:0]       store_ff [FRAME_DEPTH];
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             mode_ff, mode_in;
   logic             accept, done, toggle, ovr, is_term, m1;
   logic [IDX_W:0]   idx_inc;
   logic [REC_BYTES-1:0][7:0] view;
   logic [TERM_SPAN-1:0]      term;

   assign in_ready = q_space;
   assign accept = in_valid && q_space;
   assign is_term = (in_byte == TERM_CHAR);
   assign idx_inc = {1'b0, idx_ff} + 1'b1;

   always_comb begin
      for (int k = 0; k < REC_BYTES; k++) begin
         view[k] = (idx_ff == IDX_W'(k)) ? in_byte : store_ff[k];
      end
      for (int k = 0; k < TERM_SPAN; k++) begin
         term[k] = (idx_ff == IDX_W'(k)) ? is_term : (store_ff[k] == TERM_CHAR);
      end
   end

   always_comb begin
      done = 1'b0;
      toggle = 1'b0;
      ovr = 1'b0;
      idx_in = idx_ff;
      if (!mode_ff) begin
         if (is_term) begin
            done = 1'b1;
            toggle = 1'b1;
            idx_in = '0;
         end else if (idx_ff == IDX_W'(BIN_LEN - 1)) begin
            done = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_inc[IDX_W-1:0];
         end
      end else begin
         if (is_term) begin
            done = 1'b1;
            idx_in = '0;
         end else if (idx_inc == (IDX_W+1)'(BIN_LEN) && in_byte == TOGGLE_OP) begin
            done = 1'b1;
            toggle = 1'b1;
            idx_in = '0;
         end else if (idx_inc == (IDX_W+1)'(FRAME_DEPTH)) begin
            done = 1'b1;
            ovr = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_inc[IDX_W-1:0];
         end
      end
      m1 = mode_ff ^ toggle;
      mode_in = m1;
      if (done && !ovr && m1 && view[0] == MODE_C0 && view[1] == MODE_C1
          && term[MODE_TERM_POS]) begin
         if (view[2] == MODE_ARG_BIN) begin
            mode_in = 1'b0;
         end else if (view[2] == MODE_ARG_ASCII) begin
            mode_in = 1'b1;
         end
      end
      if (ovr) begin
         mode_in = mode_ff;
      end
   end

   assign rec_valid = accept && done;
   assign rec.ovr = ovr;
   assign rec.mode_after = mode_in;
   assign rec.toggled = mode_in != mode_ff;
   assign rec.dec_bin = !m1;
   assign rec.bytes = view;
   assign rec.term = term;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         mode_ff <= 1'b0;
      end else if (accept) begin
         idx_ff <= idx_in;
         mode_ff <= done ? mode_in : mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff[idx_ff] <= in_byte;
      end
   end

endmodule

### rtl/core/dpcfd_queue.sv
// Two-entry queue of frame records between the front and back ends.
module dpcfd_queue import dpcfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frame_rec_type push_rec,
   output logic          space,
   input  logic          pop,
   output logic          avail,
   output frame_rec_type pop_rec
);

   frame_rec_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign space = cnt_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign avail = cnt_ff != '0;
   assign do_push = push && space;
   assign do_pop = pop && avail;
   assign pop_rec = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_rec;
      end
   end

endmodule

### rtl/core/dpcfd_back.sv
// Back end: command lookup, digit joining and limit check over three pipeline stages.
module dpcfd_back import dpcfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rec_avail,
   input  frame_rec_type    rec,
   output logic             rec_pop,
   input  logic [CFG_W-1:0] lower,
   input  logic [CFG_W-1:0] upper,
   dpcfd_rsp_if.source      rsp
);

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   logic       s1_ovr_ff, s1_mode_ff, s1_tog_ff, s1_bin_ff, s1_pres_ff;
   logic [7:0] s1_code_ff, s1_param_ff;
   logic [FREQ_DIGITS-1:0][3:0] s1_dig_ff;
   logic [7:0] code_in;
   logic       pres_in;
   logic [FREQ_DIGITS-1:0][3:0] dig_in;

   logic       s2_ovr_ff, s2_mode_ff, s2_tog_ff, s2_bin_ff, s2_pres_ff;
   logic [7:0] s2_code_ff, s2_param_ff;
   logic [FREQ_W-1:0] s2_freq_ff;

   logic       s3_ovr_ff, s3_mode_ff, s3_tog_ff, s3_pres_ff, s3_rng_ff;
   logic [7:0] s3_code_ff, s3_param_ff;
   logic [FREQ_W-1:0] s3_freq_ff;
   logic       rng_in;

   assign en3 = !v3_ff || rsp.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign rec_pop = en1 && rec_avail;

   always_comb begin
      if (rec.dec_bin) begin
         code_in = rec.bytes[BIN_LEN-1];
         pres_in = (code_in == OP_FREQ_LO) || (code_in == OP_FREQ_HI);
         if (code_in == OP_FREQ_LO) begin
            dig_in = {rec.bytes[3][3:0], rec.bytes[2], rec.bytes[1], rec.bytes[0]};
         end else begin
            dig_in = {rec.bytes[0], rec.bytes[1], rec.bytes[2], rec.bytes[3][7:4]};
         end
      end else begin
         code_in = cmd_lookup(rec.bytes[0], rec.bytes[1], rec.term);
         pres_in = (code_in == CMD_FA_SET) || (code_in == CMD_FB_SET);
         for (int k = 0; k < FREQ_DIGITS; k++) begin
            dig_in[k] = rec.bytes[REC_BYTES-1-k][3:0];
         end
      end
      if (rec.ovr) begin
         code_in = '0;
         pres_in = 1'b0;
      end
   end

   assign rng_in = s2_bin_ff ? 1'b1
                 : (s2_pres_ff && s2_freq_ff >= lower && s2_freq_ff <= upper);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= rec_avail;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ovr_ff <= rec.ovr;
         s1_mode_ff <= rec.mode_after;
         s1_tog_ff <= rec.toggled && !rec.ovr;
         s1_bin_ff <= rec.dec_bin && !rec.ovr;
         s1_pres_ff <= pres_in;
         s1_code_ff <= code_in;
         s1_param_ff <= rec.ovr ? 8'd0 : rec.bytes[2];
         s1_dig_ff <= dig_in;
      end
      if (en2) begin
         s2_ovr_ff <= s1_ovr_ff;
         s2_mode_ff <= s1_mode_ff;
         s2_tog_ff <= s1_tog_ff;
         s2_bin_ff <= s1_bin_ff;
         s2_pres_ff <= s1_pres_ff;
         s2_code_ff <= s1_code_ff;
         s2_param_ff <= s1_param_ff;
         s2_freq_ff <= s1_pres_ff ? join_digits(s1_dig_ff) : '0;
      end
      if (en3) begin
         s3_ovr_ff <= s2_ovr_ff;
         s3_mode_ff <= s2_mode_ff;
         s3_tog_ff <= s2_tog_ff;
         s3_pres_ff <= s2_pres_ff;
         s3_code_ff <= s2_code_ff;
         s3_param_ff <= s2_param_ff;
         s3_freq_ff <= s2_freq_ff;
         s3_rng_ff <= rng_in;
      end
   end

   assign rsp.valid = v3_ff;
   assign rsp.protocol = s3_mode_ff;
   assign rsp.command_code = s3_code_ff;
   assign rsp.frequency = s3_freq_ff;
   assign rsp.freq_present = s3_pres_ff;
   assign rsp.freq_in_range = s3_rng_ff;
   assign rsp.param_char = s3_param_ff;
   assign rsp.mode_toggled = s3_tog_ff;
   assign rsp.overrun = s3_ovr_ff;

endmodule

### rtl/core/dual_protocol_cat_frame_decoder.sv
// Top level of the dual protocol serial command frame decoder.
// A request is taken every cycle while the two-entry record queue has room.
// A frame result is offered once the record, written into the queue at the edge that accepts
// the request ending the frame, has passed lookup, digit join and limit check; a response stall can hold it.
// Sustained throughput is one request per cycle while the response channel does not stall.
// Synchronous reset clears the mode to binary, the byte index, the queue and the pipeline.
module dual_protocol_cat_frame_decoder import dpcfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   dpcfd_req_if.sink        req_chan,
   dpcfd_rsp_if.source      rsp_chan,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   logic [CFG_W-1:0] lower_ff, upper_ff;
   logic             q_space, q_avail, q_pop, f_valid;
   frame_rec_type    f_rec, q_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= LOWER_RESET;
         upper_ff <= UPPER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOWER: lower_ff <= csr_wdata;
            CSR_UPPER: upper_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   dpcfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_byte   (req_chan.rx_byte),
      .in_ready  (req_chan.ready),
      .q_space   (q_space),
      .rec_valid (f_valid),
      .rec       (f_rec)
   );

   dpcfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid),
      .push_rec (f_rec),
      .space    (q_space),
      .pop      (q_pop),
      .avail    (q_avail),
      .pop_rec  (q_rec)
   );

   dpcfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_avail (q_avail),
      .rec       (q_rec),
      .rec_pop   (q_pop),
      .lower     (lower_ff),
      .upper     (upper_ff),
      .rsp       (rsp_chan)
   );

endmodule

### tb/dpcfd_checker.sv
// Checker of the frame decoder: watches both channels, predicts every frame result and compares.
module dpcfd_checker import dpcfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   dpcfd_req_if             req,
   dpcfd_rsp_if             rsp,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output int               mismatches,
   output int               awaiting,
   output int               frames_seen
);

   typedef struct packed {
      logic        protocol;
      logic [7:0]  command_code;
      logic [23:0] frequency;
      logic        freq_present;
      logic        freq_in_range;
      logic [7:0]  param_char;
      logic        mode_toggled;
      logic        overrun;
   } frame_result_type;

   frame_result_type expected_frames[$];
   logic             ascii_mode;
   int unsigned      store_pos;
   logic [7:0]       frame_bytes [FRAME_DEPTH];
   logic [CFG_W-1:0] lower_limit;
   logic [CFG_W-1:0] upper_limit;

   function automatic void decode_rx_byte(input logic [7:0] b);
      frame_result_type r;
      logic          old_mode;
      logic          done;
      logic          toggle;
      logic          ovr;
      logic [3:0]    d [7];
      int unsigned   freq;
      r = '0;
      old_mode = ascii_mode;
      done = 1'b0;
      toggle = 1'b0;
      ovr = 1'b0;
      freq = 0;
      if (store_pos >= FRAME_DEPTH) store_pos = 0;
      frame_bytes[store_pos] = b;
      if (!ascii_mode) begin
         if (b == TERM_CHAR) begin
            store_pos = 0; done = 1'b1; toggle = 1'b1;
         end else if (store_pos == BIN_LEN - 1) begin
            store_pos = 0; done = 1'b1;
         end else begin
            store_pos++;
         end
      end else if (b == TERM_CHAR) begin
         store_pos = 0; done = 1'b1;
      end else begin
         store_pos++;
         if (store_pos == BIN_LEN && b == TOGGLE_OP) begin
            store_pos = 0; done = 1'b1; toggle = 1'b1;
         end else if (store_pos >= FRAME_DEPTH) begin
            store_pos = 0; done = 1'b1; ovr = 1'b1;
         end
      end
      if (!done) return;
      if (ovr) begin
         r.protocol = 1'b1;
         r.overrun = 1'b1;
         expected_frames.push_back(r);
         return;
      end
      if (toggle) ascii_mode = !ascii_mode;
      r.param_char = frame_bytes[2];
      if (!ascii_mode) begin
         r.command_code = frame_bytes[BIN_LEN-1];
         r.freq_in_range = 1'b1;
         if (r.command_code == OP_FREQ_LO || r.command_code == OP_FREQ_HI) begin
            if (r.command_code == OP_FREQ_LO) begin
               d = '{frame_bytes[3][3:0], frame_bytes[2][7:4], frame_bytes[2][3:0],
                     frame_bytes[1][7:4], frame_bytes[1][3:0], frame_bytes[0][7:4],
                     frame_bytes[0][3:0]};
            end else begin
               d = '{frame_bytes[0][7:4], frame_bytes[0][3:0], frame_bytes[1][7:4],
                     frame_bytes[1][3:0], frame_bytes[2][7:4], frame_bytes[2][3:0],
                     frame_bytes[3][7:4]};
            end
            for (int k = 0; k < 7; k++) freq = freq * 10 + d[k];
            r.freq_present = 1'b1;
         end
      end else begin
         for (int i = 0; i < CMD_COUNT; i++) begin
            if (frame_bytes[0] == CMD_C0[i] && frame_bytes[1] == CMD_C1[i] &&
                frame_bytes[CMD_POS[i]] == TERM_CHAR) begin
               r.command_code = CMD_CODE[i];
               break;
            end
         end
         if (r.command_code == CMD_FA_SET || r.command_code == CMD_FB_SET) begin
            for (int k = 5; k < 12; k++) begin
               freq = freq * 10 + 4'(frame_bytes[k] - 8'd48);
            end
            r.freq_present = 1'b1;
            r.freq_in_range = (freq >= lower_limit && freq <= upper_limit);
         end else if (r.command_code == CMD_MODE_SET) begin
            if (r.param_char == MODE_ARG_BIN) ascii_mode = 1'b0;
            else if (r.param_char == MODE_ARG_ASCII) ascii_mode = 1'b1;
         end
      end
      r.frequency = freq[23:0];
      r.protocol = ascii_mode;
      r.mode_toggled = (ascii_mode != old_mode);
      expected_frames.push_back(r);
   endfunction

   function automatic void report_frame(input frame_result_type exp_r,
                                        input frame_result_type got,
                                        input logic orphan);
      if (mismatches < 10) begin
         if (orphan) begin
            $display("checker: unexpected result %p", got);
         end else begin
            $display("checker: mismatch expected %p", exp_r);
            $display("checker:          actual   %p", got);
         end
      end
      mismatches++;
   endfunction

   always @(posedge clock) begin
      frame_result_type got;
      if (reset) begin
         ascii_mode = 1'b0;
         store_pos = 0;
         lower_limit = LOWER_RESET;
         upper_limit = UPPER_RESET;
         expected_frames.delete();
         mismatches = 0;
         frames_seen = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_LOWER) lower_limit = csr_wdata;
            else upper_limit = csr_wdata;
         end
         if (req.valid && req.ready) decode_rx_byte(req.rx_byte);
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.protocol, rsp.command_code, rsp.frequency, rsp.freq_present,
                    rsp.freq_in_range, rsp.param_char, rsp.mode_toggled, rsp.overrun};
            frames_seen++;
            if (expected_frames.size() == 0) report_frame(got, got, 1'b1);
            else if (got !== expected_frames[0]) report_frame(expected_frames[0], got, 1'b0);
            if (expected_frames.size() != 0) void'(expected_frames.pop_front());
         end
      end
      awaiting <= expected_frames.size();
   end

endmodule

### tb/testbench.sv
// Top of the frame decoder testbench: clock, reset, request and limit stimulus, verdict.
module testbench;
   import dpcfd_pkg::*;

   localparam int RANDOM_ITEMS = 1780;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic             csr_index;
   logic [CFG_W-1:0] csr_wdata;
   int               mismatches;
   int               awaiting;
   int               frames_seen;
   int               sent;
   int               limit_phases;
   logic             no_gaps;
   logic             hold_rsp;
   logic             mode_known;
   logic             mode_ascii;
   logic [7:0]       frame_buf[$];

   dpcfd_req_if req_chan ();
   dpcfd_rsp_if rsp_chan ();

   dual_protocol_cat_frame_decoder dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   dpcfd_checker u_checker (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .awaiting(awaiting), .frames_seen(frames_seen));

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #(20 * 1500000);
      $display("tb: failure");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] safe_byte(input int pos);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == TERM_CHAR || (pos == BIN_LEN - 1 && b == TOGGLE_OP));
      return b;
   endfunction

   function automatic int cmd_entry(input logic [7:0] code);
      for (int i = 0; i < CMD_COUNT; i++) if (CMD_CODE[i] == code) return i;
      return 0;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   task automatic flush_frame();
      foreach (frame_buf[i]) send_byte(frame_buf[i]);
      frame_buf.delete();
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      req_chan.valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (awaiting != 0 && guard < 5000);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limits(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
      csr_we <= 1'b1;
      csr_index <= CSR_LOWER;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_UPPER;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_phases++;
   endtask

   // Fill: 0 random digits, 1 all nines, 2 any byte but the terminator in the digit positions.
   task automatic ascii_cmd(input int entry, input int len, input int fill);
      logic [7:0] code;
      logic [7:0] b;
      code = CMD_CODE[entry];
      if (!(mode_known && mode_ascii)) frame_buf.push_back(TERM_CHAR);
      frame_buf.push_back(CMD_C0[entry]);
      frame_buf.push_back(CMD_C1[entry]);
      for (int p = 2; p < len; p++) begin
         b = safe_byte(p);
         if ((code == CMD_FA_SET || code == CMD_FB_SET) && p >= 5 && p <= 11) begin
            if (fill == 1) b = "9";
            else if (fill == 0) b = 8'("0" + $urandom_range(0, 9));
         end else if (code == CMD_MODE_SET && p == 2) begin
            case ($urandom_range(0, 2))
               0: b = MODE_ARG_BIN;
               1: b = MODE_ARG_ASCII;
               default: b = safe_byte(p);
            endcase
         end
         frame_buf.push_back(b);
      end
      frame_buf.push_back(TERM_CHAR);
      mode_known = 1'b1;
      mode_ascii = !(code == CMD_MODE_SET && len == CMD_POS[entry]
                     && frame_buf[frame_buf.size() - len + 1] == MODE_ARG_BIN);
      flush_frame();
   endtask

   task automatic binary_frame(input logic [7:0] opcode);
      if (!(mode_known && !mode_ascii)) begin
         frame_buf = '{TERM_CHAR, MODE_C0, MODE_C1, MODE_ARG_BIN, TERM_CHAR};
      end
      for (int p = 0; p < BIN_LEN - 1; p++) frame_buf.push_back(8'($urandom_range(0, 255)));
      frame_buf.push_back(opcode);
      mode_known = 1'b1;
      mode_ascii = 1'b0;
      foreach (frame_buf[i]) if (i >= frame_buf.size() - BIN_LEN && frame_buf[i] == TERM_CHAR)
         mode_known = 1'b0;
      flush_frame();
   endtask

   task automatic ascii_toggle();
      if (!(mode_known && mode_ascii)) frame_buf.push_back(TERM_CHAR);
      for (int p = 0; p < BIN_LEN - 1; p++) frame_buf.push_back(safe_byte(p));
      frame_buf.push_back(TOGGLE_OP);
      mode_known = 1'b1;
      mode_ascii = 1'b0;
      flush_frame();
   endtask

   task automatic ascii_overrun();
      if (!(mode_known && mode_ascii)) frame_buf.push_back(TERM_CHAR);
      for (int p = 0; p < FRAME_DEPTH; p++) frame_buf.push_back(safe_byte(p));
      mode_known = 1'b1;
      mode_ascii = 1'b1;
      flush_frame();
   endtask

   // Response side: random stalls, quiet stretches, and one long hold-off on request.
   initial begin
      int r;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
               rsp_chan.ready <= 1'b0;
               repeat ($urandom_range(10, 40)) @(posedge clock);
            end else if (r < 12) begin
               rsp_chan.ready <= 1'b1;
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end else begin
               rsp_chan.ready <= (r < 75);
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      int kind;
      int entry;
      int len;
      int target;
      logic [CFG_W-1:0] lo;
      logic [CFG_W-1:0] hi;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      csr_we = 1'b0;
      csr_index = CSR_LOWER;
      csr_wdata = '0;
      hold_rsp = 1'b0;
      no_gaps = 1'b0;
      sent = 0;
      limit_phases = 0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every store entry is written by these two opening frames, before the frames after them read it.
      frame_buf = '{8'h00, 8'h00, 8'h00, 8'h00, TERM_CHAR};
      flush_frame();
      mode_known = 1'b1;
      mode_ascii = 1'b1;
      for (int p = 0; p < FRAME_DEPTH; p++) frame_buf.push_back("A");
      flush_frame();

      ascii_cmd(cmd_entry(CMD_MODE_SET), MODE_TERM_POS, 0);
      mode_known = 1'b0;
      frame_buf = '{8'h21, 8'h43, 8'h65, 8'h07, OP_FREQ_LO,
                    8'h12, 8'h34, 8'h56, 8'h78, OP_FREQ_HI,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h00, 8'h00, 8'h00, 8'h00, TOGGLE_OP,
                    8'h99, 8'h99, 8'h99, 8'h99, OP_FREQ_HI};
      flush_frame();
      mode_known = 1'b1;
      mode_ascii = 1'b0;
      ascii_cmd(cmd_entry(CMD_FA_SET), 13, 1);
      ascii_cmd(cmd_entry(CMD_FB_SET), 13, 2);
      ascii_cmd(cmd_entry(CMD_FA_SET), 13, 0);
      ascii_cmd(cmd_entry(8'd1), 2, 0);
      ascii_cmd(cmd_entry(8'd21), 23, 0);
      ascii_cmd(cmd_entry(8'd3), 4, 0);
      ascii_toggle();
      binary_frame(8'h5A);
      ascii_overrun();

      wait_idle();
      write_limits(24'd0, 24'd0);
      ascii_cmd(cmd_entry(CMD_FA_SET), 13, 0);
      wait_idle();
      write_limits(24'd9999999, 24'd9999999);
      ascii_cmd(cmd_entry(CMD_FB_SET), 13, 1);

      target = sent + RANDOM_ITEMS;
      while (sent < target) begin
         if (sent > target - RANDOM_ITEMS + (limit_phases - 1) * 350) begin
            wait_idle();
            case (limit_phases % 4)
               0: begin lo = 24'd0; hi = 24'd9999999; end
               1: begin lo = 24'd1000000; hi = 24'd5000000; end
               2: begin lo = 24'd9999999; hi = 24'd0; end
               default: begin
                  lo = 24'($urandom_range(0, 9999999));
                  hi = 24'($urandom_range(0, 9999999));
               end
            endcase
            write_limits(lo, hi);
            if (limit_phases == 4) hold_rsp = 1'b1;
         end
         no_gaps = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 33) begin
            case ($urandom_range(0, 3))
               0: binary_frame(OP_FREQ_LO);
               1: binary_frame(OP_FREQ_HI);
               2: binary_frame(TOGGLE_OP);
               default: binary_frame(8'($urandom_range(0, 255)));
            endcase
         end else if (kind < 70) begin
            entry = ($urandom_range(0, 2) == 0) ? cmd_entry(8'($urandom_range(7, 8)))
                                                : $urandom_range(0, CMD_COUNT - 1);
            len = CMD_POS[entry];
            if (CMD_CODE[entry] != CMD_MODE_SET && $urandom_range(0, 7) == 0)
               len = len + (($urandom_range(0, 1) == 0) ? -1 : 1);
            ascii_cmd(entry, len, ($urandom_range(0, 5) == 0) ? 2 : 0);
         end else if (kind < 78) begin
            ascii_cmd(cmd_entry(CMD_MODE_SET), MODE_TERM_POS, 0);
         end else if (kind < 85) begin
            ascii_toggle();
         end else if (kind < 88) begin
            ascii_overrun();
         end else begin
            repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom_range(0, 255)));
            mode_known = 1'b0;
            flush_frame();
         end
      end
      wait_idle();

      $display("run covered %0d request bytes, %0d frame results, %0d limit settings",
               sent, frames_seen, limit_phases);
      if (mismatches == 0 && awaiting == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
